// ----- rtl/stt_pkg.sv -----
// Package for the source text tokenizer: token and keyword codes, token record type,
// character constants, character classes, saturating counters and keyword matching.
// No dependencies.
package stt_pkg;

  localparam int OFFSET_BITS = 24;
  localparam int COLUMN_BITS = 16;
  localparam int LINE_BITS   = 24;
  localparam int PREFIX_BITS = 48;

  // Output field widths on the stream port.
  localparam int OUT_OFF_W  = 24;
  localparam int OUT_COL_W  = 16;
  localparam int OUT_LINE_W = 24;
  localparam int TDATA_W    = 104;

  // Output queue.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam logic [OFFSET_BITS-1:0] OFF_MAX  = {OFFSET_BITS{1'b1}};
  localparam logic [COLUMN_BITS-1:0] COL_MAX  = {COLUMN_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};

  typedef enum logic [2:0] {
    KIND_OP    = 3'd0,
    KIND_NUM   = 3'd1,
    KIND_KW    = 3'd2,
    KIND_ID    = 3'd3,
    KIND_PUNCT = 3'd4,
    KIND_STR   = 3'd5,
    KIND_EOF   = 3'd6,
    KIND_ERR   = 3'd7
  } token_kind_e;

  typedef enum logic [2:0] {
    KW_NONE   = 3'd0,
    KW_INT    = 3'd1,
    KW_BOOL   = 3'd2,
    KW_IF     = 3'd3,
    KW_FOR    = 3'd4,
    KW_WHILE  = 3'd5,
    KW_ELSE   = 3'd6,
    KW_RETURN = 3'd7
  } keyword_e;

  typedef enum logic [4:0] {
    MODE_IDLE = 5'b00001,
    MODE_OP   = 5'b00010,
    MODE_NUM  = 5'b00100,
    MODE_WORD = 5'b01000,
    MODE_STR  = 5'b10000
  } lex_mode_e;

  typedef struct packed {
    token_kind_e             kind;
    keyword_e                kw;
    logic [7:0]              first;
    logic [OFFSET_BITS-1:0]  start;
    logic [OFFSET_BITS-1:0]  len;
    logic [LINE_BITS-1:0]    line;
    logic [COLUMN_BITS-1:0]  col;
    logic                    last;
  } token_t;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam logic [PREFIX_BITS-1:0] TXT_INT    = 48'h0000_0069_6E74;
  localparam logic [PREFIX_BITS-1:0] TXT_BOOL   = 48'h0000_626F_6F6C;
  localparam logic [PREFIX_BITS-1:0] TXT_IF     = 48'h0000_0000_6966;
  localparam logic [PREFIX_BITS-1:0] TXT_FOR    = 48'h0000_0066_6F72;
  localparam logic [PREFIX_BITS-1:0] TXT_WHILE  = 48'h0077_6869_6C65;
  localparam logic [PREFIX_BITS-1:0] TXT_ELSE   = 48'h0000_656C_7365;
  localparam logic [PREFIX_BITS-1:0] TXT_RETURN = 48'h7265_7475_726E;

  function automatic logic is_op(logic [7:0] c);
    return c == "+" || c == "-" || c == "*" || c == "/" || c == "=" ||
           c == "<" || c == ">" || c == "&" || c == "|";
  endfunction

  function automatic logic is_punct(logic [7:0] c);
    return c == "." || c == "," || c == ";" || c == "(" || c == ")" ||
           c == "{" || c == "}" || c == "[" || c == "]";
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_word(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
           c == CH_FF || c == CH_CR;
  endfunction

  function automatic logic [OFFSET_BITS-1:0] inc_off(logic [OFFSET_BITS-1:0] v);
    return (v == OFF_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [COLUMN_BITS-1:0] inc_col(logic [COLUMN_BITS-1:0] v);
    return (v == COL_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [LINE_BITS-1:0] inc_line(logic [LINE_BITS-1:0] v);
    return (v == LINE_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [OFFSET_BITS-1:0] len_of(int unsigned n);
    return OFFSET_BITS'(n);
  endfunction

  // The prefix holds the first six bytes of the word, first byte highest.
  function automatic keyword_e kw_match(logic [PREFIX_BITS-1:0] p,
                                        logic [OFFSET_BITS-1:0] n);
    keyword_e k;
    k = KW_NONE;
    if (n == len_of(3) && p == TXT_INT)         k = KW_INT;
    else if (n == len_of(4) && p == TXT_BOOL)   k = KW_BOOL;
    else if (n == len_of(2) && p == TXT_IF)     k = KW_IF;
    else if (n == len_of(3) && p == TXT_FOR)    k = KW_FOR;
    else if (n == len_of(5) && p == TXT_WHILE)  k = KW_WHILE;
    else if (n == len_of(4) && p == TXT_ELSE)   k = KW_ELSE;
    else if (n == len_of(6) && p == TXT_RETURN) k = KW_RETURN;
    return k;
  endfunction

  function automatic token_t mk_tok(token_kind_e kind, keyword_e kw, logic [7:0] first,
                                    logic [OFFSET_BITS-1:0] start,
                                    logic [OFFSET_BITS-1:0] len,
                                    logic [LINE_BITS-1:0] line,
                                    logic [COLUMN_BITS-1:0] col);
    token_t t;
    t.kind  = kind;
    t.kw    = kw;
    t.first = first;
    t.start = start;
    t.len   = len;
    t.line  = line;
    t.col   = col;
    t.last  = 1'b0;
    return t;
  endfunction

endpackage

// ----- rtl/source_text_tokenizer.sv -----
// Source text tokenizer top level: byte stream in, token stream out.
// Depends on stt_pkg for types, character classes and keyword matching.
//
// Channel  Dir  Transfer contents
// s_axis   in   tdata[7:0] char_code; tuser end_of_input
// m_axis   out  tdata keyword_code .. token_column; tuser token_kind; tlast last_of_run
//
// When a byte is taken, the lexer state registers update on that edge
// and the tokens it causes are written into a four-entry output queue.
// A byte that ends a run and emits its own token (or an end mark after a run)
// produces two tokens, which the output side drains one at a time.
// s_axis_tready is high while the queue holds two tokens or fewer.
// Reset returns the mode, the counters and the queue pointers and count to their start; no clearing pass is needed.
module source_text_tokenizer
  import stt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [7:0] char_code
  input  logic               s_axis_tuser,   // [0] end_of_input
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // [2:0] keyword_code, [10:3] first_char, [34:11] start_offset,
  // [58:35] token_length, [82:59] token_line, [98:83] token_column, [103:99] zero
  output logic [TDATA_W-1:0] m_axis_tdata,
  output logic [2:0]         m_axis_tuser,   // [2:0] token_kind
  output logic               m_axis_tlast    // last_of_run
);

  lex_mode_e              mode_q, mode_d;
  logic                   dq_q, dq_d;
  logic                   bs_q, bs_d;
  logic [OFFSET_BITS-1:0] off_q, off_d;
  logic [LINE_BITS-1:0]   line_q, line_d;
  logic [COLUMN_BITS-1:0] col_q, col_d;

  logic [OFFSET_BITS-1:0] ts_off_q, ts_off_d;
  logic [LINE_BITS-1:0]   ts_line_q, ts_line_d;
  logic [COLUMN_BITS-1:0] ts_col_q, ts_col_d;
  logic [OFFSET_BITS-1:0] len_q, len_d;
  logic [PREFIX_BITS-1:0] prefix_q, prefix_d;
  logic [7:0]             first_q, first_d;

  token_t                 queue_q [QDEPTH];
  logic [QPTR_W-1:0]      rd_ptr_q, wr_ptr_q;
  logic [QCNT_W-1:0]      cnt_q;

  logic                   s_hs, m_hs;
  logic [7:0]             ch;
  logic                   cont;
  logic                   adv;
  logic [7:0]             quote;
  token_kind_e            run_kind;
  keyword_e               run_kw;
  token_t                 tok_a, tok_b, head;
  logic                   push_a, push_b;
  logic [1:0]             npush;

  assign s_hs  = s_axis_tvalid && s_axis_tready;
  assign m_hs  = m_axis_tvalid && m_axis_tready;
  assign ch    = s_axis_tdata;
  assign quote = dq_q ? CH_DQUOTE : CH_SQUOTE;

  always_comb begin
    case (mode_q)
      MODE_OP:   cont = is_op(ch);
      MODE_NUM:  cont = is_digit(ch);
      MODE_WORD: cont = is_word(ch);
      default:   cont = 1'b0;
    endcase
  end

  // Kind of the pending run when it is flushed.
  always_comb begin
    run_kw = KW_NONE;
    case (mode_q)
      MODE_NUM:  run_kind = KIND_NUM;
      MODE_WORD: begin
        run_kw   = kw_match(prefix_q, len_q);
        run_kind = (run_kw != KW_NONE) ? KIND_KW : KIND_ID;
      end
      default:   run_kind = KIND_OP;
    endcase
  end

  always_comb begin
    mode_d    = mode_q;
    dq_d      = dq_q;
    bs_d      = bs_q;
    off_d     = off_q;
    line_d    = line_q;
    col_d     = col_q;
    ts_off_d  = ts_off_q;
    ts_line_d = ts_line_q;
    ts_col_d  = ts_col_q;
    len_d     = len_q;
    prefix_d  = prefix_q;
    first_d   = first_q;
    tok_a     = mk_tok(run_kind, run_kw, first_q, ts_off_q, len_q, ts_line_q, ts_col_q);
    tok_b     = mk_tok(KIND_EOF, KW_NONE, 8'd0, off_q, '0, line_q, col_q);
    push_a    = 1'b0;
    push_b    = 1'b0;
    adv       = 1'b0;

    if (s_hs) begin
      if (s_axis_tuser) begin
        // End mark: flush whatever is pending, then EOF at the current position.
        if (mode_q == MODE_STR) begin
          tok_a.kind = KIND_ERR;
          tok_a.kw   = KW_NONE;
          push_a     = 1'b1;
        end else if (mode_q != MODE_IDLE) begin
          push_a = 1'b1;
        end
        mode_d = MODE_IDLE;
        bs_d   = 1'b0;
        push_b = 1'b1;
      end else if (mode_q == MODE_STR) begin
        if (ch == quote && !bs_q) begin
          tok_a.kind = KIND_STR;
          tok_a.kw   = KW_NONE;
          push_a     = 1'b1;
          mode_d     = MODE_IDLE;
          bs_d       = 1'b0;
        end else begin
          len_d = inc_off(len_q);
          bs_d  = (ch == CH_BSLASH);
        end
        adv = 1'b1;
      end else if (cont) begin
        if (len_q < len_of(6)) begin
          prefix_d = {prefix_q[PREFIX_BITS-9:0], ch};
        end
        len_d = inc_off(len_q);
        adv   = 1'b1;
      end else begin
        if (mode_q != MODE_IDLE) begin
          push_a = 1'b1;
          mode_d = MODE_IDLE;
        end
        if (is_space(ch)) begin
          mode_d = MODE_IDLE;
        end else if (is_op(ch) || is_digit(ch) || is_word(ch)) begin
          mode_d    = is_op(ch) ? MODE_OP : (is_digit(ch) ? MODE_NUM : MODE_WORD);
          ts_off_d  = off_q;
          ts_line_d = line_q;
          ts_col_d  = col_q;
          len_d     = len_of(1);
          prefix_d  = {{(PREFIX_BITS-8){1'b0}}, ch};
          first_d   = ch;
        end else if (is_punct(ch)) begin
          tok_b  = mk_tok(KIND_PUNCT, KW_NONE, ch, off_q, len_of(1), line_q, col_q);
          push_b = 1'b1;
        end else if (ch == CH_DQUOTE || ch == CH_SQUOTE) begin
          mode_d    = MODE_STR;
          dq_d      = (ch == CH_DQUOTE);
          bs_d      = 1'b0;
          ts_off_d  = inc_off(off_q);
          ts_line_d = line_q;
          ts_col_d  = col_q;
          len_d     = '0;
          first_d   = ch;
        end else begin
          tok_b  = mk_tok(KIND_ERR, KW_NONE, ch, off_q, len_of(1), line_q, col_q);
          push_b = 1'b1;
        end
        adv = 1'b1;
      end

      if (adv) begin
        if (ch == CH_LF) begin
          line_d = inc_line(line_q);
          col_d  = '0;
        end else begin
          col_d = inc_col(col_q);
        end
        off_d = inc_off(off_q);
      end
    end

    tok_b.last = 1'b1;
    tok_a.last = !push_b;
  end

  assign npush = {1'b0, push_a} + {1'b0, push_b};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      dq_q     <= 1'b0;
      bs_q     <= 1'b0;
      off_q    <= '0;
      line_q   <= LINE_BITS'(1);
      col_q    <= '0;
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      mode_q   <= mode_d;
      dq_q     <= dq_d;
      bs_q     <= bs_d;
      off_q    <= off_d;
      line_q   <= line_d;
      col_q    <= col_d;
      wr_ptr_q <= wr_ptr_q + QPTR_W'(npush);
      if (m_hs) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + QCNT_W'(npush) - QCNT_W'(m_hs);
    end
  end

  // Token start fields and the queue payload carry no reset.
  always_ff @(posedge clk_i) begin
    ts_off_q  <= ts_off_d;
    ts_line_q <= ts_line_d;
    ts_col_q  <= ts_col_d;
    len_q     <= len_d;
    prefix_q  <= prefix_d;
    first_q   <= first_d;
    if (push_a) begin
      queue_q[wr_ptr_q] <= tok_a;
      if (push_b) begin
        queue_q[wr_ptr_q + 1'b1] <= tok_b;
      end
    end else if (push_b) begin
      queue_q[wr_ptr_q] <= tok_b;
    end
  end

  assign s_axis_tready = (cnt_q <= QCNT_W'(QDEPTH - 2));
  assign m_axis_tvalid = (cnt_q != '0);
  assign head          = queue_q[rd_ptr_q];
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.last;
  assign m_axis_tdata  = {5'd0,
                          OUT_COL_W'(head.col),
                          OUT_LINE_W'(head.line),
                          OUT_OFF_W'(head.len),
                          OUT_OFF_W'(head.start),
                          head.first,
                          head.kw};

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH))
    else $error("output queue count beyond its depth");

  a_mode_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(mode_q))
    else $error("lexer mode is not one-hot");

  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_hs && s_axis_tuser |=> mode_q == MODE_IDLE && !bs_q)
    else $error("lexer not idle after end mark");

  a_eof_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_EOF |-> m_axis_tlast)
    else $error("EOF token without tlast");

  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q != '0)
    else $error("line counter reached zero");

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for source_text_tokenizer: directed table, random text, back-pressure.
// Uses types and constants from stt_pkg; expected tokens come from a local behavioral lexer.
module testbench;
  import stt_pkg::*;

  typedef struct packed {
    token_kind_e            kind;
    keyword_e               kw;
    logic [7:0]             first;
    logic [OUT_OFF_W-1:0]   start;
    logic [OUT_OFF_W-1:0]   len;
    logic [OUT_LINE_W-1:0]  line;
    logic [OUT_COL_W-1:0]   col;
    logic                   last;
  } tok_rec_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
    logic       typed;
  } stim_row_t;

  typedef enum logic [2:0] {LX_IDLE, LX_OP, LX_NUM, LX_WORD, LX_STR} lx_mode_e;
  typedef enum logic [2:0] {
    CC_SPACE, CC_OP, CC_DIGIT, CC_WORD, CC_PUNCT, CC_QUOTE, CC_OTHER
  } char_class_e;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata = 8'h00;
  logic               s_axis_tuser = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic [2:0]         m_axis_tuser;
  logic               m_axis_tlast;

  source_text_tokenizer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  tok_rec_t tokens_due[$];
  tok_rec_t step_tokens[$];
  int       err_count = 0;
  int       bytes_sent = 0;
  int       typed_idx = 0;
  int       hold_req = 0;
  bit       src_calm = 1'b0;
  bit       snk_calm = 1'b0;

  // Lexer state mirrored from the block.
  lx_mode_e               lx_mode = LX_IDLE;
  logic                   lx_dquote = 1'b0;
  logic                   lx_bslash = 1'b0;
  logic [OUT_OFF_W-1:0]   lx_off = '0;
  logic [OUT_LINE_W-1:0]  lx_line = 24'd1;
  logic [OUT_COL_W-1:0]   lx_col = '0;
  logic [OUT_OFF_W-1:0]   tk_off = '0;
  logic [OUT_LINE_W-1:0]  tk_line = '0;
  logic [OUT_COL_W-1:0]   tk_col = '0;
  logic [OUT_OFF_W-1:0]   tk_len = '0;
  logic [47:0]            tk_prefix = '0;
  logic [7:0]             tk_first = '0;

  string      kw_names [7] = '{"int", "bool", "if", "for", "while", "else", "return"};
  string      op_chars = "+-*/=<>&|";
  string      punct_chars = ".,;(){}[]";
  logic [7:0] blank_chars [6] = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};

  // Directed text: unknown bytes and an end mark at reset, a keyword cut by a digit,
  // an operator run cut by a punctuator, a seven-letter word that starts like a keyword,
  // a string with an escaped quote and a newline, and an unterminated string.
  stim_row_t dir_rows [27] = '{
    '{8'h00, 1'b0, 1'b1}, '{8'hFF, 1'b0, 1'b1}, '{8'hA5, 1'b1, 1'b1},
    '{CH_LF, 1'b0, 1'b0},
    '{"w", 1'b0, 1'b0}, '{"h", 1'b0, 1'b0}, '{"i", 1'b0, 1'b0}, '{"l", 1'b0, 1'b0},
    '{"e", 1'b0, 1'b0}, '{"1", 1'b0, 1'b0}, '{"+", 1'b0, 1'b0}, '{"(", 1'b0, 1'b0},
    '{"r", 1'b0, 1'b0}, '{"e", 1'b0, 1'b0}, '{"t", 1'b0, 1'b0}, '{"u", 1'b0, 1'b0},
    '{"r", 1'b0, 1'b0}, '{"n", 1'b0, 1'b0}, '{"_", 1'b0, 1'b0}, '{" ", 1'b0, 1'b0},
    '{"'", 1'b0, 1'b0}, '{"\\", 1'b0, 1'b0}, '{"'", 1'b0, 1'b0}, '{CH_LF, 1'b0, 1'b0},
    '{"'", 1'b0, 1'b0}, '{"\"", 1'b0, 1'b0}, '{8'h5A, 1'b1, 1'b0}
  };

  tok_rec_t typed_toks [3] = '{
    '{KIND_ERR, KW_NONE, 8'h00, 24'd0, 24'd1, 24'd1, 16'd0, 1'b1},
    '{KIND_ERR, KW_NONE, 8'hFF, 24'd1, 24'd1, 24'd1, 16'd1, 1'b1},
    '{KIND_EOF, KW_NONE, 8'h00, 24'd2, 24'd0, 24'd1, 16'd2, 1'b1}
  };

  function automatic logic [23:0] sat24(logic [23:0] v);
    return (&v) ? v : v + 24'd1;
  endfunction

  function automatic logic [15:0] sat16(logic [15:0] v);
    return (&v) ? v : v + 16'd1;
  endfunction

  function automatic char_class_e class_of(logic [7:0] c);
    if (c inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR}) return CC_SPACE;
    if (c inside {"+", "-", "*", "/", "=", "<", ">", "&", "|"}) return CC_OP;
    if (c inside {["0":"9"]}) return CC_DIGIT;
    if (c inside {["a":"z"], ["A":"Z"], "_"}) return CC_WORD;
    if (c inside {".", ",", ";", "(", ")", "{", "}", "[", "]"}) return CC_PUNCT;
    if (c inside {CH_DQUOTE, CH_SQUOTE}) return CC_QUOTE;
    return CC_OTHER;
  endfunction

  // Only the first six bytes are kept, so the length check guards longer words.
  function automatic keyword_e keyword_for(logic [47:0] p, logic [23:0] n);
    if (n == 24'd3 && p == 48'("int"))    return KW_INT;
    if (n == 24'd4 && p == 48'("bool"))   return KW_BOOL;
    if (n == 24'd2 && p == 48'("if"))     return KW_IF;
    if (n == 24'd3 && p == 48'("for"))    return KW_FOR;
    if (n == 24'd5 && p == 48'("while"))  return KW_WHILE;
    if (n == 24'd4 && p == 48'("else"))   return KW_ELSE;
    if (n == 24'd6 && p == 48'("return")) return KW_RETURN;
    return KW_NONE;
  endfunction

  function automatic void add_tok(token_kind_e k, keyword_e w, logic [7:0] f,
                                  logic [23:0] s, logic [23:0] n, logic [23:0] ln,
                                  logic [15:0] cl);
    tok_rec_t t;
    t = '{k, w, f, s, n, ln, cl, 1'b0};
    step_tokens.push_back(t);
  endfunction

  function automatic void add_run_tok();
    keyword_e w;
    w = KW_NONE;
    if (lx_mode == LX_WORD) w = keyword_for(tk_prefix, tk_len);
    if (lx_mode == LX_NUM)
      add_tok(KIND_NUM, KW_NONE, tk_first, tk_off, tk_len, tk_line, tk_col);
    else if (lx_mode == LX_OP)
      add_tok(KIND_OP, KW_NONE, tk_first, tk_off, tk_len, tk_line, tk_col);
    else
      add_tok((w == KW_NONE) ? KIND_ID : KIND_KW, w, tk_first, tk_off, tk_len, tk_line,
              tk_col);
  endfunction

  function automatic void move_past(logic [7:0] c);
    if (c == CH_LF) begin
      lx_line = sat24(lx_line);
      lx_col = '0;
    end else begin
      lx_col = sat16(lx_col);
    end
    lx_off = sat24(lx_off);
  endfunction

  // Works out the tokens one accepted transfer causes and updates the mirrored state.
  task automatic predict_tokens(input logic [7:0] c, input logic eoi);
    char_class_e cc;
    cc = class_of(c);
    step_tokens.delete();
    if (eoi) begin
      if (lx_mode == LX_STR)
        add_tok(KIND_ERR, KW_NONE, tk_first, tk_off, tk_len, tk_line, tk_col);
      else if (lx_mode != LX_IDLE)
        add_run_tok();
      lx_mode = LX_IDLE;
      lx_bslash = 1'b0;
      add_tok(KIND_EOF, KW_NONE, 8'h00, lx_off, 24'd0, lx_line, lx_col);
    end else if (lx_mode == LX_STR) begin
      if (c == (lx_dquote ? CH_DQUOTE : CH_SQUOTE) && !lx_bslash) begin
        add_tok(KIND_STR, KW_NONE, tk_first, tk_off, tk_len, tk_line, tk_col);
        lx_mode = LX_IDLE;
        lx_bslash = 1'b0;
      end else begin
        tk_len = sat24(tk_len);
        lx_bslash = (c == CH_BSLASH);
      end
      move_past(c);
    end else if ((lx_mode == LX_OP && cc == CC_OP) || (lx_mode == LX_NUM && cc == CC_DIGIT) ||
                 (lx_mode == LX_WORD && cc == CC_WORD)) begin
      if (tk_len < 24'd6) tk_prefix = {tk_prefix[39:0], c};
      tk_len = sat24(tk_len);
      move_past(c);
    end else begin
      if (lx_mode != LX_IDLE) begin
        add_run_tok();
        lx_mode = LX_IDLE;
      end
      case (cc)
        CC_SPACE: ;
        CC_OP, CC_DIGIT, CC_WORD: begin
          lx_mode = (cc == CC_OP) ? LX_OP : ((cc == CC_DIGIT) ? LX_NUM : LX_WORD);
          tk_off = lx_off;
          tk_line = lx_line;
          tk_col = lx_col;
          tk_len = 24'd1;
          tk_prefix = {40'd0, c};
          tk_first = c;
        end
        CC_PUNCT: add_tok(KIND_PUNCT, KW_NONE, c, lx_off, 24'd1, lx_line, lx_col);
        CC_QUOTE: begin
          lx_mode = LX_STR;
          lx_dquote = (c == CH_DQUOTE);
          lx_bslash = 1'b0;
          tk_off = sat24(lx_off);
          tk_line = lx_line;
          tk_col = lx_col;
          tk_len = '0;
          tk_first = c;
        end
        default: add_tok(KIND_ERR, KW_NONE, c, lx_off, 24'd1, lx_line, lx_col);
      endcase
      move_past(c);
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1'b1;
  endtask

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    err_count++;
    $display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  // Offers one byte or end mark and waits for its transfer.
  task automatic send_char(input logic [7:0] ch, input logic eoi, input bit typed);
    int gap;
    gap = src_calm ? 0 : $urandom_range(0, 16);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = ch;
    s_axis_tuser = eoi;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_tokens(ch, eoi);
    if (typed) begin
      tokens_due.push_back(typed_toks[typed_idx]);
      typed_idx++;
    end else begin
      foreach (step_tokens[i]) tokens_due.push_back(step_tokens[i]);
    end
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0, 1'b0);
  endtask

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return "_";
  endfunction

  // A quoted string with random content; a quote inside is always escaped.
  task automatic send_string(input bit closed);
    logic [7:0] q;
    logic [7:0] b;
    bit         after_bs;
    int         n;
    q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
    after_bs = 1'b0;
    n = $urandom_range(0, 6);
    send_char(q, 1'b0, 1'b0);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: b = CH_BSLASH;
        1: b = q;
        2: b = CH_LF;
        3: b = (q == CH_DQUOTE) ? CH_SQUOTE : CH_DQUOTE;
        default: b = 8'($urandom_range(32, 126));
      endcase
      if (b == q && !after_bs) send_char(CH_BSLASH, 1'b0, 1'b0);
      send_char(b, 1'b0, 1'b0);
      after_bs = (b == CH_BSLASH);
    end
    if (closed) begin
      if (after_bs) send_char("x", 1'b0, 1'b0);
      send_char(q, 1'b0, 1'b0);
    end else begin
      send_char(8'($urandom_range(0, 255)), 1'b1, 1'b0);
    end
  endtask

  task automatic random_text(input int upto);
    string s;
    int    n;
    while (bytes_sent < upto) begin
      if ($urandom_range(0, 39) == 0) begin
        src_calm = ($urandom_range(0, 3) == 0);
        snk_calm = ($urandom_range(0, 3) == 0);
      end
      case ($urandom_range(0, 24))
        0, 1, 2: send_text(kw_names[$urandom_range(0, 6)]);
        3, 4, 5: begin
          n = $urandom_range(1, 8);
          repeat (n) send_char(rand_letter(), 1'b0, 1'b0);
        end
        6, 7, 8: begin
          n = $urandom_range(1, 5);
          repeat (n) send_char(8'("0" + $urandom_range(0, 9)), 1'b0, 1'b0);
        end
        9, 10: begin
          n = $urandom_range(1, 3);
          repeat (n) send_char(op_chars[$urandom_range(0, 8)], 1'b0, 1'b0);
        end
        11, 12: send_char(punct_chars[$urandom_range(0, 8)], 1'b0, 1'b0);
        13, 14: send_string(1'b1);
        15: send_string(1'b0);
        16, 17, 18, 19: send_char(blank_chars[$urandom_range(0, 5)], 1'b0, 1'b0);
        20, 21, 22: send_char(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        23: send_char(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        default: begin
          // Near misses of a keyword: one byte short or one letter too many.
          s = kw_names[$urandom_range(0, 6)];
          if ($urandom_range(0, 1)) begin
            send_text(s.substr(0, s.len() - 2));
          end else begin
            send_text(s);
            send_char(rand_letter(), 1'b0, 1'b0);
          end
        end
      endcase
    end
  endtask

  // Receiver: random stalls, plus a long hold-off when the sender asks for one.
  initial begin
    int gap;
    forever begin
      @(negedge clk_i);
      if (hold_req > 0) begin
        m_axis_tready = 1'b0;
        repeat (hold_req) @(negedge clk_i);
        hold_req = 0;
      end
      gap = snk_calm ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        m_axis_tready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin : token_check
    tok_rec_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (tokens_due.size() == 0) begin
        flag_mismatch("token with none due", m_axis_tuser, 0);
      end else begin
        want = tokens_due.pop_front();
        if (m_axis_tuser !== want.kind) flag_mismatch("token_kind", m_axis_tuser, want.kind);
        if (m_axis_tdata[2:0] !== want.kw)
          flag_mismatch("keyword_code", m_axis_tdata[2:0], want.kw);
        if (m_axis_tdata[10:3] !== want.first)
          flag_mismatch("first_char", m_axis_tdata[10:3], want.first);
        if (m_axis_tdata[34:11] !== want.start)
          flag_mismatch("start_offset", m_axis_tdata[34:11], want.start);
        if (m_axis_tdata[58:35] !== want.len)
          flag_mismatch("token_length", m_axis_tdata[58:35], want.len);
        if (m_axis_tdata[82:59] !== want.line)
          flag_mismatch("token_line", m_axis_tdata[82:59], want.line);
        if (m_axis_tdata[98:83] !== want.col)
          flag_mismatch("token_column", m_axis_tdata[98:83], want.col);
        if (m_axis_tlast !== want.last) flag_mismatch("last_of_run", m_axis_tlast, want.last);
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) send_char(dir_rows[i].ch, dir_rows[i].eoi, dir_rows[i].typed);

    random_text(bytes_sent + 930);

    // Keep the output stalled while punctuators pour in, so the queue fills.
    hold_req = 300;
    src_calm = 1'b1;
    repeat (40) send_char(";", 1'b0, 1'b0);
    src_calm = 1'b0;

    random_text(bytes_sent + 930);

    // An operator run flushed by the end mark, then a keyword on a new line.
    send_text("zz+");
    send_char(8'h00, 1'b1, 1'b0);
    send_char(CH_LF, 1'b0, 1'b0);
    send_text("if");
    send_char(8'hFF, 1'b1, 1'b0);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;

    while (tokens_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
